/* rtl/core/qfib_pkg.sv */
// qfib_pkg: shared types, codes and constants of the quad and fan index batcher
// no dependencies; imported by every module of the batcher core
`timescale 1ns / 1ps

package qfib_pkg;

  // request kinds
  localparam logic [1:0] FUNC_QUAD  = 2'd0;
  localparam logic [1:0] FUNC_FAN   = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TRI  = 2'd0;
  localparam logic [1:0] KIND_DRAW = 2'd1;
  localparam logic [1:0] KIND_BIND = 2'd2;

  // geometry constants
  localparam int QUAD_VERTS   = 4;
  localparam int QUAD_INDICES = 6;
  localparam int TRI_INDICES  = 3;

  // parameter defaults
  localparam int DEF_VERTEX_CAPACITY = 1024;
  localparam int DEF_INDEX_CAPACITY  = 2048;
  localparam int DEF_MAX_FAN_EDGES   = 20;

  // field widths
  localparam int EDGE_W  = 5;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 12;
  localparam int TEX_W   = 16;
  localparam int CAP_W   = 18;

  typedef struct packed {
    logic [1:0]        func;
    logic [TEX_W-1:0]  texture_id;
    logic [EDGE_W-1:0] edge_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic [CNT_W-1:0] draw_count;
    logic [TEX_W-1:0] bind_texture;
    logic [IDX_W-1:0] vertex_base;
    logic             last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_draw;
    logic emit_bind;
    logic emit_tri;
    logic last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_draw;
    logic need_bind;
    logic need_tri;
    logic tri_last;
  } status_t;

endpackage

/* rtl/core/qfib_ctrl.sv */
// qfib_ctrl: request sequencer and output valid control of the batcher
// depends on qfib_pkg for the command and status structs
`timescale 1ns / 1ps

module qfib_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  qfib_pkg::status_t status,
  output qfib_pkg::cmd_t    cmd
);
  import qfib_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DRAW = 2'd1;
  localparam logic [1:0] S_BIND = 2'd2;
  localparam logic [1:0] S_TRI  = 2'd3;

  logic [1:0] state, state_next;
  logic       plan_bind, plan_bind_next;
  logic       plan_tri, plan_tri_next;
  logic       out_valid_next;
  logic       can_load;

  assign can_load = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    plan_bind_next = plan_bind;
    plan_tri_next  = plan_tri;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept     = 1'b1;
          plan_bind_next = status.need_bind;
          plan_tri_next  = status.need_tri;
          if (status.need_draw) state_next = S_DRAW;
          else if (status.need_bind) state_next = S_BIND;
          else if (status.need_tri) state_next = S_TRI;
        end
      end
      S_DRAW: begin
        if (can_load) begin
          cmd.emit_draw  = 1'b1;
          cmd.last       = !plan_bind && !plan_tri;
          out_valid_next = 1'b1;
          if (plan_bind) state_next = S_BIND;
          else if (plan_tri) state_next = S_TRI;
          else state_next = S_IDLE;
        end
      end
      S_BIND: begin
        if (can_load) begin
          cmd.emit_bind  = 1'b1;
          cmd.last       = !plan_tri;
          out_valid_next = 1'b1;
          state_next     = plan_tri ? S_TRI : S_IDLE;
        end
      end
      S_TRI: begin
        if (can_load) begin
          cmd.emit_tri   = 1'b1;
          cmd.last       = status.tri_last;
          out_valid_next = 1'b1;
          if (status.tri_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      plan_bind <= 1'b0;
      plan_tri  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      plan_bind <= plan_bind_next;
      plan_tri  <= plan_tri_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_emit_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.emit_draw, cmd.emit_bind, cmd.emit_tri}))
    else $error("more than one command in a cycle");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_draw || cmd.emit_bind || cmd.emit_tri) |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_tri && status.tri_last) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after final triangle");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_draw || cmd.emit_bind || cmd.emit_tri) |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

/* rtl/core/qfib_dpath.sv */
// qfib_dpath: batch counters, bound texture, plan flags and result register
// depends on qfib_pkg; driven by commands from qfib_ctrl
`timescale 1ns / 1ps

module qfib_dpath #(
  parameter int VERTEX_CAPACITY = qfib_pkg::DEF_VERTEX_CAPACITY,
  parameter int INDEX_CAPACITY  = qfib_pkg::DEF_INDEX_CAPACITY,
  parameter int MAX_FAN_EDGES   = qfib_pkg::DEF_MAX_FAN_EDGES
) (
  input  logic                clk,
  input  logic                rst,
  input  qfib_pkg::in_item_t  in_data,
  input  qfib_pkg::cmd_t      cmd,
  output qfib_pkg::status_t   status,
  output qfib_pkg::out_item_t out_data
);
  import qfib_pkg::*;

  localparam int VCW    = $clog2(VERTEX_CAPACITY + 1);
  localparam int ICW    = $clog2(INDEX_CAPACITY + 1);
  localparam int VSUM_W = VCW + 1;
  localparam int ISUM_W = ICW + 2;
  localparam int E3_W   = EDGE_W + 2;

  logic [VCW-1:0]    vertex_count;
  logic [ICW-1:0]    index_count;
  logic [TEX_W-1:0]  current_texture;
  logic              texture_valid;

  logic              req_quad;
  logic [TEX_W-1:0]  req_tex;
  logic [EDGE_W-1:0] req_edges;
  logic [EDGE_W-1:0] tri_idx;

  // plan of the incoming request
  logic [EDGE_W-1:0] e_sat;
  logic [E3_W-1:0]   e3;
  logic              has_idx, tex_change, quad_ovf, fan_ovf, fan_huge, fan_zero;

  always_comb begin
    if (6'(in_data.edge_count) > 6'(MAX_FAN_EDGES)) e_sat = EDGE_W'(MAX_FAN_EDGES);
    else e_sat = in_data.edge_count;
    e3         = E3_W'({e_sat, 1'b0}) + E3_W'(e_sat);
    has_idx    = (index_count != '0);
    fan_zero   = (in_data.edge_count == '0);
    tex_change = !texture_valid || (current_texture != in_data.texture_id);
    quad_ovf   = (VSUM_W'(vertex_count) + VSUM_W'(QUAD_VERTS) > VSUM_W'(VERTEX_CAPACITY))
              || (ISUM_W'(index_count) + ISUM_W'(QUAD_INDICES) > ISUM_W'(INDEX_CAPACITY));
    fan_ovf    = (VSUM_W'(vertex_count) + VSUM_W'(e_sat) + VSUM_W'(1)
                  > VSUM_W'(VERTEX_CAPACITY))
              || (ISUM_W'(index_count) + ISUM_W'(e3) > ISUM_W'(INDEX_CAPACITY));
    fan_huge   = (CAP_W'(e_sat) + CAP_W'(1) > CAP_W'(VERTEX_CAPACITY))
              || (CAP_W'(e3) > CAP_W'(INDEX_CAPACITY));

    status = '0;
    unique case (in_data.func)
      FUNC_QUAD: begin
        status.need_draw = (tex_change || quad_ovf) && has_idx;
        status.need_bind = tex_change;
        status.need_tri  = 1'b1;
      end
      FUNC_FAN: begin
        status.need_draw = !fan_zero && fan_ovf && has_idx;
        status.need_tri  = !fan_zero && !fan_huge;
      end
      FUNC_FLUSH: status.need_draw = has_idx;
      default: status = '0;
    endcase
    status.tri_last = (tri_idx == (req_quad ? EDGE_W'(2) : req_edges) - EDGE_W'(1));
  end

  // triangle indices
  logic [IDX_W-1:0] v10, i10, idx_b, idx_c;
  logic [VCW-1:0]   v_add;
  logic [ICW-1:0]   i_add;

  always_comb begin
    v10   = IDX_W'(vertex_count);
    i10   = IDX_W'(tri_idx);
    idx_b = v10 + i10 + IDX_W'(1);
    // fan closure wraps back to the first rim vertex
    if (!req_quad && status.tri_last) idx_c = v10 + IDX_W'(1);
    else idx_c = v10 + i10 + IDX_W'(2);
    v_add = req_quad ? VCW'(QUAD_VERTS) : VCW'(req_edges) + VCW'(1);
    i_add = req_quad ? ICW'(QUAD_INDICES) : ICW'({req_edges, 1'b0}) + ICW'(req_edges);
  end

  // next result
  out_item_t out_data_next;

  always_comb begin
    out_data_next      = '0;
    out_data_next.last = cmd.last;
    if (cmd.emit_draw) begin
      out_data_next.kind       = KIND_DRAW;
      out_data_next.draw_count = CNT_W'(index_count);
    end else if (cmd.emit_bind) begin
      out_data_next.kind         = KIND_BIND;
      out_data_next.bind_texture = req_tex;
    end else begin
      out_data_next.kind        = KIND_TRI;
      out_data_next.index_a     = v10;
      out_data_next.index_b     = idx_b;
      out_data_next.index_c     = idx_c;
      out_data_next.vertex_base = v10;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count    <= '0;
      index_count     <= '0;
      current_texture <= '0;
      texture_valid   <= 1'b0;
    end else begin
      if (cmd.emit_draw) begin
        vertex_count <= '0;
        index_count  <= '0;
      end
      if (cmd.emit_bind) begin
        current_texture <= req_tex;
        texture_valid   <= 1'b1;
      end
      if (cmd.emit_tri && status.tri_last) begin
        vertex_count <= vertex_count + v_add;
        index_count  <= index_count + i_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_quad  <= (in_data.func == FUNC_QUAD);
      req_tex   <= in_data.texture_id;
      req_edges <= e_sat;
      tri_idx   <= '0;
    end else if (cmd.emit_tri) begin
      tri_idx <= tri_idx + EDGE_W'(1);
    end
    if (cmd.emit_draw || cmd.emit_bind || cmd.emit_tri) begin
      out_data <= out_data_next;
    end
  end

endmodule

/* rtl/core/quad_fan_index_batcher_core.sv */
// quad_fan_index_batcher_core: top level of the quad and fan index batcher
// depends on qfib_pkg, qfib_ctrl and qfib_dpath
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// in       into core  in_valid / in_stall    qfib_pkg::in_item_t  (func, texture_id, edge_count)
// out      from core  out_valid / out_stall  qfib_pkg::out_item_t (one result per transfer)
//
// an item is taken when idle; its results then leave one per cycle unless out_stall holds them:
//   draw (if the batch flushes), bind (quads only, on a texture change), then its triangles
// the step that takes an item emits no result of its own; its results follow it in order
// results pass through the single result register, loaded at most once per cycle by the sequencer
// the next item is taken while the final result still sits in the result register
// an output stall holds only the result steps; rst is synchronous and clears the batch
module quad_fan_index_batcher_core #(
  parameter int VERTEX_CAPACITY = qfib_pkg::DEF_VERTEX_CAPACITY,
  parameter int INDEX_CAPACITY  = qfib_pkg::DEF_INDEX_CAPACITY,
  parameter int MAX_FAN_EDGES   = qfib_pkg::DEF_MAX_FAN_EDGES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qfib_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qfib_pkg::out_item_t out_data
);
  import qfib_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: accepts items, walks draw / bind / triangle results
  qfib_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: batch counts, bound texture, index math, result register
  qfib_dpath #(
    .VERTEX_CAPACITY (VERTEX_CAPACITY),
    .INDEX_CAPACITY  (INDEX_CAPACITY),
    .MAX_FAN_EDGES   (MAX_FAN_EDGES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
